// ===== rtl/float32_exp_lut64_poly2_assert.svh =====
// Assertion macros for the float32 exp pipeline.
// Included by the top level; compiles to nothing under SYNTHESIS.
`ifndef FLOAT32_EXP_LUT64_POLY2_ASSERT_SVH
`define FLOAT32_EXP_LUT64_POLY2_ASSERT_SVH
`ifndef SYNTHESIS
`define FE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FE_ASSERT(lbl, clk, rst, prop, msg)
`define FE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/fexp_pkg.sv =====
// Package for the float32 exp pipeline: item types, constants, 2^(j/64) table
// and single-precision multiply/add functions with round-to-nearest-even.
`timescale 1ns / 1ps
package fexp_pkg;

  typedef struct packed {
    logic [31:0] x_bits;
    logic        last_in;
  } exp_in_t;

  typedef struct packed {
    logic [31:0] y_bits;
    logic        last_out;
  } exp_out_t;

  localparam int unsigned NumStages = 12;

  localparam logic [31:0] MagicBias   = 32'h4B40_0000;
  localparam logic [31:0] NegMagic    = 32'hCB40_0000;
  localparam logic [30:0] ZeroCutMag  = 31'h42CF_F1B4;
  localparam logic [30:0] InfCutMag   = 31'h42B1_7217;
  localparam logic [31:0] Log2eX64    = 32'h42B8_AA3B;
  localparam logic [31:0] NegLn2Hi    = 32'hBC31_8000;
  localparam logic [31:0] NegLn2Lo    = 32'h365E_8083;
  localparam logic [31:0] PolyC2      = 32'h3EFF_FF85;
  localparam logic [31:0] ExpMinBits  = 32'hC100_0000;
  localparam logic [31:0] ExpMaxBits  = 32'h3F80_0000;
  localparam logic [31:0] PosInf      = 32'h7F80_0000;
  localparam logic [31:0] DefaultNan  = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit    = 32'h0040_0000;

  localparam logic [31:0] Pow2Rom [64] = '{
    32'h3F800000, 32'h3F8164D2, 32'h3F82CD87, 32'h3F843A29,
    32'h3F85AAC3, 32'h3F871F62, 32'h3F88980F, 32'h3F8A14D5,
    32'h3F8B95C2, 32'h3F8D1ADF, 32'h3F8EA43A, 32'h3F9031DC,
    32'h3F91C3D3, 32'h3F935A2B, 32'h3F94F4F0, 32'h3F96942D,
    32'h3F9837F0, 32'h3F99E046, 32'h3F9B8D3A, 32'h3F9D3EDA,
    32'h3F9EF532, 32'h3FA0B051, 32'h3FA27043, 32'h3FA43516,
    32'h3FA5FED7, 32'h3FA7CD94, 32'h3FA9A15B, 32'h3FAB7A3A,
    32'h3FAD583F, 32'h3FAF3B79, 32'h3FB123F6, 32'h3FB311C4,
    32'h3FB504F3, 32'h3FB6FD92, 32'h3FB8FBAF, 32'h3FBAFF5B,
    32'h3FBD08A4, 32'h3FBF179A, 32'h3FC12C4D, 32'h3FC346CD,
    32'h3FC5672A, 32'h3FC78D75, 32'h3FC9B9BE, 32'h3FCBEC15,
    32'h3FCE248C, 32'h3FD06334, 32'h3FD2A81E, 32'h3FD4F35B,
    32'h3FD744FD, 32'h3FD99D16, 32'h3FDBFBB8, 32'h3FDE60F5,
    32'h3FE0CCDF, 32'h3FE33F89, 32'h3FE5B907, 32'h3FE8396A,
    32'h3FEAC0C7, 32'h3FED4F30, 32'h3FEFE4BA, 32'h3FF28177,
    32'h3FF5257D, 32'h3FF7D0DF, 32'h3FFA83B3, 32'h3FFD3E0C
  };

  // Normalize, denormalize and round a wide significand.
  // Value is sig * 2^(e - 127 - 49).
  function automatic logic [31:0] round_pack(logic s, logic [49:0] sig,
                                             logic signed [11:0] e);
    logic [5:0]         lz;
    logic [49:0]        nsig;
    logic [49:0]        dsig;
    logic signed [11:0] ne;
    logic signed [11:0] sh;
    logic [30:0]        mag;
    logic               grd;
    logic               stk;
    logic               ovf;
    logic               inc;
    lz   = '0;
    dsig = '0;
    grd  = 1'b0;
    stk  = 1'b0;
    ovf  = 1'b0;
    mag  = '0;
    for (int i = 0; i < 50; i++) begin
      if (sig[i]) lz = 6'(49 - i);
    end
    nsig = sig << lz;
    ne   = e - 12'(lz);
    if (ne > 0) begin
      ovf = (ne >= 12'sd255);
      mag = {ne[7:0], nsig[48:26]};
      grd = nsig[25];
      stk = |nsig[24:0];
    end else begin
      // shift into the subnormal range, folding lost bits into sticky
      sh = 12'sd1 - ne;
      if (sh >= 12'sd50) begin
        dsig = '0;
        stk  = 1'b1;
      end else begin
        dsig = nsig >> sh;
        stk  = |(nsig << (12'sd50 - sh));
      end
      mag = {8'd0, dsig[48:26]};
      grd = dsig[25];
      stk = stk | (|dsig[24:0]);
    end
    inc = grd & (stk | mag[0]);
    mag = mag + 31'(inc);
    if (sig == '0) return {s, 31'd0};
    if (ovf || mag[30:23] == 8'hFF) return {s, PosInf[30:0]};
    return {s, mag};
  endfunction

  // Single-precision multiply.
  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic               s;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [47:0]        prod;
    logic signed [11:0] e;
    logic               an;
    logic               bn;
    logic               ai;
    logic               bi;
    logic               az;
    logic               bz;
    s    = a[31] ^ b[31];
    an   = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    bn   = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    ai   = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    bi   = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    az   = (a[30:0] == '0);
    bz   = (b[30:0] == '0);
    ma   = {a[30:23] != 8'd0, a[22:0]};
    mb   = {b[30:23] != 8'd0, b[22:0]};
    prod = ma * mb;
    e    = $signed({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]})
         + $signed({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - 12'sd126;
    if (an) return a | QuietBit;
    if (bn) return b | QuietBit;
    if (ai || bi) return (az || bz) ? DefaultNan : {s, PosInf[30:0]};
    if (az || bz) return {s, 31'd0};
    return round_pack(s, {prod, 2'b00}, e);
  endfunction

  // Single-precision add.
  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [49:0] av;
    logic [49:0] bv;
    logic [49:0] bs;
    logic [49:0] sum;
    logic        an;
    logic        bn;
    logic        ai;
    logic        bi;
    an = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    ai = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    bi = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    if (a[30:0] < b[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d  = eb - es;
    av = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
    bv = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
    // align the smaller operand with a sticky bit
    if (d >= 8'd50) bs = {49'd0, |bv};
    else bs = (bv >> d) | {49'd0, |(bv << (8'd50 - d))};
    sum = (a[31] ^ b[31]) ? av - bs : av + bs;
    if (an) return a | QuietBit;
    if (bn) return b | QuietBit;
    if (ai && bi && (a[31] != b[31])) return DefaultNan;
    if (ai) return a;
    if (bi) return b;
    if (sum == '0) return {a[31] & b[31], 31'd0};
    return round_pack(big[31], sum, $signed({4'd0, eb}) + 12'sd1);
  endfunction

endpackage

// ===== rtl/float32_exp_lut64_poly2.sv =====
// Throughput: one item per cycle; each stage holds one single-precision
// multiply or add (stage 4 holds the two Cody-Waite products side by side).
// The whole pipe holds, and arg is stalled, only while a result waits on res
// under res_stall.
// Reset: rst (synchronous, active high) clears all stage valid bits.
// Top level: float32 exp(x) by 64-entry table and degree-2 polynomial.
// Depends on fexp_pkg and float32_exp_lut64_poly2_assert.svh.
`timescale 1ns / 1ps
`include "float32_exp_lut64_poly2_assert.svh"
module float32_exp_lut64_poly2
  import fexp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     arg_valid,
  output logic     arg_stall,
  input  exp_in_t  arg,
  output logic     res_valid,
  input  logic     res_stall,
  output exp_out_t res
);

  logic [NumStages-1:0] v;
  logic                 en;

  logic [31:0] s1_x,  s2_x,  s3_x,  s4_x;
  logic [31:0] s1_m,  s2_n,  s3_n2;
  logic [31:0] s4_a,  s4_b,  s5_b,  s5_t1, s6_t;
  logic [31:0] s7_t,  s7_c,  s8_t,  s8_d,  s9_p;
  logic [31:0] s3_l,  s4_l,  s5_l,  s6_l,  s7_l,  s8_l,  s9_l,  s10_l, s10_g, s11_h;
  logic [31:0] s3_sn, s4_sn, s5_sn, s6_sn, s7_sn, s8_sn, s9_sn, s10_sn, s11_sn;
  logic [31:0] y;
  logic [NumStages-2:0] sp;
  logic [31:0] spv [NumStages-1];
  logic [NumStages-1:0] last;

  // Special-case decode of the argument
  logic        x_nan;
  logic        x_low;
  logic        x_high;
  always_comb begin
    x_nan  = (arg.x_bits[30:23] == 8'hFF) && (arg.x_bits[22:0] != '0);
    x_low  = arg.x_bits[31] && (arg.x_bits[30:0] > ZeroCutMag);
    x_high = !arg.x_bits[31] && (arg.x_bits[30:0] > InfCutMag);
  end

  // Table word and scale from the rounded index
  logic [31:0] eo;
  logic [31:0] en_c;
  logic [31:0] l_c;
  logic [31:0] sn_c;
  always_comb begin
    eo   = {s2_n[31:6], 6'd0} << 17;
    en_c = eo;
    if ($signed(en_c) < $signed(ExpMinBits)) en_c = ExpMinBits;
    if ($signed(ExpMaxBits) < $signed(en_c)) en_c = ExpMaxBits;
    l_c  = Pow2Rom[s2_n[5:0]] + (eo - en_c);
    sn_c = en_c + ExpMaxBits;
  end

  // Advance the whole pipe unless the result is held
  assign en        = !(v[NumStages-1] && res_stall);
  assign arg_stall = v[NumStages-1] && res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NumStages-2:0], arg_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last   <= {last[NumStages-2:0], arg.last_in};
      sp     <= {sp[NumStages-3:0], x_nan || x_low || x_high};
      spv[0] <= x_nan ? (arg.x_bits | QuietBit) : (x_high ? PosInf : 32'd0);
      for (int i = 1; i < NumStages - 1; i++) spv[i] <= spv[i-1];
      // stage 1: x * 64/ln2
      s1_x   <= arg.x_bits;
      s1_m   <= fmul(arg.x_bits, Log2eX64);
      // stage 2: add magic bias
      s2_x   <= s1_x;
      s2_n   <= fadd(s1_m, MagicBias);
      // stage 3: remove bias, fetch table word and scale
      s3_x   <= s2_x;
      s3_n2  <= fadd(s2_n, NegMagic);
      s3_l   <= l_c;
      s3_sn  <= sn_c;
      // stage 4: both Cody-Waite products
      s4_x   <= s3_x;
      s4_a   <= fmul(s3_n2, NegLn2Hi);
      s4_b   <= fmul(s3_n2, NegLn2Lo);
      s4_l   <= s3_l;
      s4_sn  <= s3_sn;
      // stage 5: high part of reduction
      s5_t1  <= fadd(s4_a, s4_x);
      s5_b   <= s4_b;
      s5_l   <= s4_l;
      s5_sn  <= s4_sn;
      // stage 6: low part of reduction
      s6_t   <= fadd(s5_b, s5_t1);
      s6_l   <= s5_l;
      s6_sn  <= s5_sn;
      // stage 7: t * c2
      s7_t   <= s6_t;
      s7_c   <= fmul(s6_t, PolyC2);
      s7_l   <= s6_l;
      s7_sn  <= s6_sn;
      // stage 8: t * (t * c2)
      s8_t   <= s7_t;
      s8_d   <= fmul(s7_t, s7_c);
      s8_l   <= s7_l;
      s8_sn  <= s7_sn;
      // stage 9: p = t + ...
      s9_p   <= fadd(s8_t, s8_d);
      s9_l   <= s8_l;
      s9_sn  <= s8_sn;
      // stage 10: l * p
      s10_g  <= fmul(s9_l, s9_p);
      s10_l  <= s9_l;
      s10_sn <= s9_sn;
      // stage 11: l + l*p
      s11_h  <= fadd(s10_l, s10_g);
      s11_sn <= s10_sn;
      // stage 12: scale, or pick the special result
      y      <= sp[NumStages-2] ? spv[NumStages-2] : fmul(s11_h, s11_sn);
    end
  end

  assign res_valid     = v[NumStages-1];
  assign res.y_bits    = y;
  assign res.last_out  = last[NumStages-1];

  // Checks on pipeline control
  `FE_ASSERT(a_accept_enters, clk, rst, (arg_valid && !arg_stall) |=> v[0], "accepted item lost")
  `FE_ASSERT(a_hold_on_stall, clk, rst, (res_valid && res_stall) |=> $stable(v), "pipe moved in stall")
  `FE_ASSERT(a_advance, clk, rst, (en && v[NumStages-2]) |=> res_valid, "item dropped at output")
  `FE_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !res_valid, "valid after reset")

endmodule
